/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the resampler RTL.
// Every macro samples on posedge clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked at every rising clock edge outside reset.
`define ASSERT_SYNC(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("resampler assertion failed");

// Same-cycle implication from a condition to a consequence.
`define ASSERT_IMPLY(label, cond, conseq) \
  `ASSERT_SYNC(label, (cond) |-> (conseq))

`endif

/* hw/rtl/lir_pkg.sv */
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other RTL file but assert_macros.svh uses this package.
package lir_pkg;

  // Default widths of the datapath.
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COUNT_BITS  = 24;

  // Interpolated words per input word at the minimum step of 1/16.
  localparam int MAX_INTERP = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP       = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_LENGTH = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULT,
    ST_EMIT,
    ST_FINAL,
    ST_DONE
  } lir_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic emit_interp;
    logic emit_final;
    logic commit;
  } lir_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cond;
    logic final_due;
    logic out_free;
    logic finished;
  } lir_status_t;

endpackage

/* hw/rtl/lir_if.sv */
// Valid/ready channel interfaces for the resampler: input, output and config.
// Depends on lir_pkg for default widths.
interface lir_in_if #(
  parameter int SAMPLE_BITS = lir_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          final_req;

  modport source (output valid, sample, final_req, input ready);
  modport sink (input valid, sample, final_req, output ready);
endinterface

interface lir_out_if #(
  parameter int SAMPLE_BITS = lir_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          run_end;
  logic                          stream_end;

  modport source (output valid, out_sample, run_end, stream_end, input ready);
  modport sink (input valid, out_sample, run_end, stream_end, output ready);
endinterface

interface lir_cfg_if #(
  parameter int DATA_BITS = lir_pkg::DEF_COUNT_BITS
);
  logic                                    valid;
  logic                                    ready;
  logic [lir_pkg::CFG_INDEX_BITS-1:0]      index;
  logic [DATA_BITS-1:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/lir_ctrl.sv */
// Controller state machine of the resampler: sequences one input word.
// Depends on lir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lir_pkg::lir_status_t status,
  output lir_pkg::lir_cmd_t    cmd
);
  import lir_pkg::*;

  lir_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // After the final word, further words are taken and dropped.
        if (in_valid && !status.finished) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.cond) begin
          state_next = ST_MULT;
        end else if (status.final_due) begin
          state_next = ST_FINAL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MULT: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Status already reflects the advanced position here.
        if (status.out_free) begin
          cmd.emit_interp = 1'b1;
          if (status.cond) begin
            state_next = ST_MULT;
          end else if (status.final_due) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The output register is loaded only when it is free.
  `ASSERT_IMPLY(a_emit_needs_slot, cmd.emit_interp || cmd.emit_final, status.out_free)
  // A multiply is always followed by the emit step.
  `ASSERT_SYNC(a_mul_then_emit, cmd.mul |=> (state == ST_EMIT))
  // Words are taken only between items.
  `ASSERT_IMPLY(a_ready_only_idle, in_ready, state == ST_IDLE)

endmodule

/* hw/rtl/lir_datapath.sv */
// Datapath of the resampler: position, counters, multiplier and output register.
// Depends on lir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lir_datapath #(
  parameter int SAMPLE_BITS   = lir_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS     = lir_pkg::DEF_FRAC_BITS,
  parameter int COUNT_BITS    = lir_pkg::DEF_COUNT_BITS,
  parameter int CFG_DATA_BITS = COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lir_pkg::lir_cmd_t                   cmd,
  output lir_pkg::lir_status_t                status,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_final,
  input  logic                                cfg_we,
  input  logic [lir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_run_end,
  output logic                                out_stream_end
);
  import lir_pkg::*;

  localparam int STEP_BITS = FRAC_BITS + 5;
  localparam int POS_BITS  = COUNT_BITS + FRAC_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int N_BITS    = $clog2(MAX_INTERP + 1);
  localparam logic [STEP_BITS-1:0] STEP_MIN = STEP_BITS'(1) << (FRAC_BITS - 4);
  localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRAC_BITS;

  // Configuration.
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS-1:0] out_length;

  // Track state.
  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic [COUNT_BITS-1:0]         in_index;
  logic [POS_BITS-1:0]           read_pos;
  logic [COUNT_BITS-1:0]         out_count;
  logic                          finished;

  // Per-item working registers.
  logic signed [SAMPLE_BITS-1:0] cur;
  logic                          is_final;
  logic [N_BITS-1:0]             n;
  logic signed [PROD_BITS-1:0]   prod;
  logic                          se_flag;

  logic [STEP_BITS-1:0]          adv;
  logic [COUNT_BITS-1:0]         want;
  logic [COUNT_BITS-1:0]         oc_inc;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_BITS-1:0]   prod_full;
  logic signed [PROD_BITS-1:0]   prev_ext;
  logic signed [PROD_BITS-1:0]   total;
  logic signed [PROD_BITS-1:0]   shifted;
  logic                          round_up;
  logic signed [SAMPLE_BITS-1:0] interp_val;

  // Step clamp, loop condition, pending final word, output slot and finished status.
  always_comb begin
    adv    = (step < STEP_MIN) ? STEP_MIN : step;
    want   = in_index - COUNT_BITS'(1);
    oc_inc = out_count + COUNT_BITS'(1);
    status.cond = (in_index != '0) && (n < N_BITS'(MAX_INTERP)) &&
                  (out_count < out_length) &&
                  (read_pos[POS_BITS-1:FRAC_BITS] == want);
    status.final_due = is_final && (out_count < out_length);
    status.out_free  = !out_valid || out_ready;
    status.finished  = finished;
  end

  // Multiplier operands: the difference and the unsigned fraction.
  always_comb begin
    diff      = (SAMPLE_BITS + 1)'(cur) - (SAMPLE_BITS + 1)'(prev_sample);
    frac_s    = $signed({1'b0, read_pos[FRAC_BITS-1:0]});
    prod_full = diff * frac_s;
  end

  // Add the scaled previous sample, then shift right rounding toward zero.
  always_comb begin
    prev_ext   = PROD_BITS'(prev_sample);
    total      = (prev_ext <<< FRAC_BITS) + prod;
    shifted    = total >>> FRAC_BITS;
    round_up   = total[PROD_BITS-1] && (total[FRAC_BITS-1:0] != '0);
    interp_val = shifted[SAMPLE_BITS-1:0] + SAMPLE_BITS'(round_up);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_ONE;
      out_length <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:       step       <= cfg_data[STEP_BITS-1:0];
        REG_OUT_LENGTH: out_length <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Track state and per-item counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      in_index    <= '0;
      read_pos    <= '0;
      out_count   <= '0;
      finished    <= 1'b0;
      n           <= '0;
    end else begin
      if (cmd.load_in) begin
        n <= '0;
      end
      if (cmd.mul) begin
        read_pos  <= read_pos + POS_BITS'(adv);
        out_count <= oc_inc;
        n         <= n + N_BITS'(1);
      end
      if (cmd.emit_final) begin
        out_count <= oc_inc;
      end
      if (cmd.commit) begin
        prev_sample <= cur;
        in_index    <= in_index + COUNT_BITS'(1);
        finished    <= finished || is_final;
      end
    end
  end

  // Payload registers of the working item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur      <= in_sample;
      is_final <= in_final;
    end
    if (cmd.mul) begin
      prod    <= prod_full;
      se_flag <= (oc_inc == out_length);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_interp || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word; run_end is set when no further word follows for this input.
  always_ff @(posedge clk) begin
    if (cmd.emit_interp) begin
      out_sample     <= interp_val;
      out_run_end    <= !(status.cond || status.final_due);
      out_stream_end <= se_flag;
    end else if (cmd.emit_final) begin
      out_sample     <= cur;
      out_run_end    <= 1'b1;
      out_stream_end <= 1'b1;
    end
  end

  // The per-input word count stays within the step limit.
  `ASSERT_SYNC(a_n_bound, n <= N_BITS'(MAX_INTERP))
  // The final word closes both the run and the track.
  `ASSERT_SYNC(a_final_flags, cmd.emit_final |=> (out_valid && out_run_end && out_stream_end))
  // Each committed item advances the input index by one.
  `ASSERT_SYNC(a_index_step, cmd.commit |=> (in_index == $past(in_index) + COUNT_BITS'(1)))

endmodule

/* hw/rtl/linear_interp_resampler_top.sv */
// Linear interpolation resampler: a taken word passes a check step, then for each interpolated
// result a multiply step and an emit step (add and round); the final word has its own emit step.
// A commit step closes each input word; the next word is taken only after it, back in idle.
// Output stalls hold the sequencer in its emit step; one result register parts the sides.
// Reset is synchronous: position, counters and flags clear, step to 1.0, length to all ones.
module linear_interp_resampler_top #(
  parameter int SAMPLE_BITS = lir_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = lir_pkg::DEF_FRAC_BITS,
  parameter int COUNT_BITS  = lir_pkg::DEF_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst,
  lir_in_if.sink   samples_in,
  lir_out_if.source samples_out,
  lir_cfg_if.sink  cfg
);
  import lir_pkg::*;

  localparam int CFG_DATA_BITS =
    (FRAC_BITS + 5 > COUNT_BITS) ? FRAC_BITS + 5 : COUNT_BITS;

  lir_cmd_t    cmd;
  lir_status_t status;
  logic        in_ready;
  logic        out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic        out_run_end;
  logic        out_stream_end;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Config writes are always taken; data is widened to the register width.
  assign cfg.ready = 1'b1;
  assign cfg_data  = CFG_DATA_BITS'(cfg.data);

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lir_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRAC_BITS     (FRAC_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .CFG_DATA_BITS (CFG_DATA_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_sample      (samples_in.sample),
    .in_final       (samples_in.final_req),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg_data),
    .out_ready      (samples_out.ready),
    .out_valid      (out_valid),
    .out_sample     (out_sample),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end)
  );

  // Channel outputs.
  assign samples_in.ready       = in_ready;
  assign samples_out.valid      = out_valid;
  assign samples_out.out_sample = out_sample;
  assign samples_out.run_end    = out_run_end;
  assign samples_out.stream_end = out_stream_end;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the linear interpolation resampler top level.
// Depends on lir_pkg and the lir_in_if, lir_out_if and lir_cfg_if channel interfaces.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lir_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int CB = DEF_COUNT_BITS;
  localparam int PB = CB + FB;
  localparam int STEP_BITS = FB + 5;
  localparam logic [STEP_BITS-1:0] STEP_FLOOR = STEP_BITS'(1) << (FB - 4);
  localparam logic [STEP_BITS-1:0] STEP_UNIT = STEP_BITS'(1) << FB;
  localparam longint ONE = longint'(1) << FB;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 run_end;
    logic                 stream_end;
  } res_word_t;

  logic clk;
  logic rst;

  lir_in_if  in_ch ();
  lir_out_if out_ch ();
  lir_cfg_if cfg_ch ();

  linear_interp_resampler_top uut (
    .clk         (clk),
    .rst         (rst),
    .samples_in  (in_ch),
    .samples_out (out_ch),
    .cfg         (cfg_ch)
  );

  // Shadow copy of the configuration and the resampler state.
  logic [STEP_BITS-1:0] step_reg;
  logic [CB-1:0]        len_reg;
  logic signed [SB-1:0] prev_smp;
  logic [CB-1:0]        next_idx;
  logic [PB-1:0]        read_pos;
  logic [CB-1:0]        emitted;
  logic                 track_done;

  res_word_t pending_res[$];
  res_word_t head_res;
  int        errors;
  int        words_in;
  int        words_out;
  int        cfg_writes;
  int        cycles;
  int        hold_req;
  bit        tx_idle;
  bit        rx_idle;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result words that one accepted input word causes.
  function automatic void interpolate_word(input logic signed [SB-1:0] smp, input logic fin);
    int                   n;
    int                   i;
    logic [STEP_BITS-1:0] adv;
    logic [CB-1:0]        want;
    longint               base_v;
    longint               cur_v;
    longint               frac_v;
    longint               total;
    longint               value;
    res_word_t            burst[MAX_INTERP+1];
    if (track_done) return;
    n = 0;
    cur_v = smp;
    base_v = prev_smp;
    adv = (step_reg < STEP_FLOOR) ? STEP_FLOOR : step_reg;
    // Interpolate while the read position sits between the previous and this word.
    if (next_idx != 0) begin
      want = next_idx - 1'b1;
      while (n < MAX_INTERP && emitted < len_reg && read_pos[PB-1:FB] == want) begin
        frac_v = read_pos[FB-1:0];
        total = base_v * ONE + (cur_v - base_v) * frac_v;
        value = total / ONE;
        emitted = emitted + 1'b1;
        burst[n].smp = value[SB-1:0];
        burst[n].run_end = 1'b0;
        burst[n].stream_end = (emitted == len_reg);
        n++;
        read_pos = read_pos + adv;
      end
    end
    // The last word of the track is passed through once, then the block stops.
    if (fin) begin
      if (emitted < len_reg) begin
        emitted = emitted + 1'b1;
        burst[n].smp = smp;
        burst[n].run_end = 1'b0;
        burst[n].stream_end = 1'b1;
        n++;
      end
      track_done = 1'b1;
    end
    prev_smp = smp;
    next_idx = next_idx + 1'b1;
    if (n > 0) burst[n-1].run_end = 1'b1;
    for (i = 0; i < n; i++) pending_res.push_back(burst[i]);
  endfunction

  // Extremes come up often; the rest is uniform.
  function automatic logic signed [SB-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SB'($urandom);
    endcase
  endfunction

  // Offer one input word and record its expected results once it is taken.
  task automatic send_word(input logic signed [SB-1:0] smp, input logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.final_req <= fin;
    do @(posedge clk); while (!in_ch.ready);
    interpolate_word(smp, fin);
    words_in++;
  endtask

  // Stop offering words and wait until every expected result has come.
  task automatic pause_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the block finish any word that causes no result.
  task automatic await_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one configuration register; callers make sure the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CB-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_STEP) step_reg = val[STEP_BITS-1:0];
    else len_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls per word, plus long hold-offs on request.
  initial begin
    int gap;
    int hold;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end else begin
        gap = rx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && hold_req == 0);
      @(negedge clk);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got sample %0d run_end %0b %s %0b",
                 $time, out_ch.out_sample, out_ch.run_end, "stream_end",
                 out_ch.stream_end);
      end else begin
        head_res = pending_res.pop_front();
        words_out++;
        if (out_ch.out_sample !== head_res.smp) begin
          errors++;
          $display("%0t: out_sample expected %0d, got %0d", $time, head_res.smp,
                   out_ch.out_sample);
        end
        if (out_ch.run_end !== head_res.run_end) begin
          errors++;
          $display("%0t: run_end expected %0b, got %0b", $time, head_res.run_end,
                   out_ch.run_end);
        end
        if (out_ch.stream_end !== head_res.stream_end) begin
          errors++;
          $display("%0t: stream_end expected %0b, got %0b", $time, head_res.stream_end,
                   out_ch.stream_end);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // The very first word has no predecessor, so it yields nothing.
  task automatic test_first_word();
    send_word(16'sh7fff, 1'b0);
    await_idle();
  endtask

  // At a step of 1.0 the fraction stays zero and each word repeats its predecessor.
  task automatic test_unit_step();
    write_reg(REG_STEP, CB'(STEP_UNIT));
    write_reg(REG_OUT_LENGTH, '1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'shffff, 1'b0);
    send_word(16'sh0001, 1'b0);
    await_idle();
  endtask

  // Smallest step, a step below the floor and garbage above the step field.
  task automatic test_fine_steps();
    write_reg(REG_STEP, CB'(STEP_FLOOR));
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    await_idle();
    write_reg(REG_STEP, 24'he00000);
    send_word(16'shffff, 1'b0);
    await_idle();
    write_reg(REG_STEP, 24'd100);
    send_word(16'sh3039, 1'b0);
    await_idle();
  endtask

  // Large steps skip whole input words without any result.
  task automatic test_coarse_steps();
    int i;
    write_reg(REG_STEP, 24'h100000);
    for (i = 0; i < 4; i++) send_word(draw_sample(), 1'b0);
    await_idle();
    write_reg(REG_STEP, 24'h1fffff);
    for (i = 0; i < 2; i++) send_word(draw_sample(), 1'b0);
    await_idle();
  endtask

  // Segments of random words, each under a fresh step and idling mix.
  task automatic test_random_stream();
    int seg;
    int i;
    logic [CB-1:0] val;
    for (seg = 0; seg < 10; seg++) begin
      await_idle();
      case ($urandom_range(0, 9))
        0: val = CB'($urandom_range(0, int'(STEP_FLOOR) - 1));
        1: val = CB'($urandom_range(262144, 2097151));
        2: val = CB'(STEP_FLOOR);
        default: val = CB'($urandom_range(4097, 200000));
      endcase
      val[CB-1:STEP_BITS] = (CB - STEP_BITS)'($urandom_range(0, 7));
      write_reg(REG_STEP, val);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 16; i++) begin
        if ($urandom_range(0, 15) == 0) pause_until_drained();
        send_word(draw_sample(), 1'b0);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    await_idle();
  endtask

  // Hold the result side off for a long stretch while words keep coming.
  task automatic test_backpressure();
    int i;
    write_reg(REG_STEP, CB'(STEP_FLOOR));
    tx_idle = 1'b0;
    hold_req = 400;
    for (i = 0; i < 30; i++) send_word(draw_sample(), 1'b0);
    tx_idle = 1'b1;
    await_idle();
  endtask

  // Reach the output count, feed words while stopped, then reopen the count.
  task automatic test_output_limit();
    int n;
    write_reg(REG_STEP, 24'h040000);
    write_reg(REG_OUT_LENGTH, emitted + 2'd2);
    n = 0;
    while (emitted != len_reg && n < 100) begin
      send_word(draw_sample(), 1'b0);
      n++;
    end
    // With a step of 4.0 the read position is at least three words ahead here.
    send_word(draw_sample(), 1'b0);
    await_idle();
    write_reg(REG_OUT_LENGTH, '0);
    send_word(draw_sample(), 1'b0);
    await_idle();
    write_reg(REG_OUT_LENGTH, '1);
  endtask

  // Close the track with the final word; anything after it is ignored.
  task automatic test_track_end();
    int i;
    write_reg(REG_STEP, 24'd20000);
    write_reg(REG_OUT_LENGTH, emitted + 6'd40);
    for (i = 0; i < 6; i++) send_word(draw_sample(), 1'b0);
    send_word(draw_sample(), 1'b1);
    for (i = 0; i < 3; i++) send_word(draw_sample(), i[0]);
    await_idle();
  endtask

  // Reset once, then run every test in turn.
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.final_req = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    step_reg = STEP_UNIT;
    len_reg = '1;
    prev_smp = '0;
    next_idx = '0;
    read_pos = '0;
    emitted = '0;
    track_done = 1'b0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    cfg_writes = 0;
    hold_req = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_word();
    test_unit_step();
    test_fine_steps();
    test_coarse_steps();
    test_random_stream();
    test_backpressure();
    test_output_limit();
    test_track_end();

    $display("Checked %0d result words from %0d input words across %0d register writes.",
             words_out, words_in, cfg_writes);
    $display("Run covered clamped, fine and coarse steps, stalls, the output count and track end.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
